### hw/rtl/i2cm_pkg.sv
// ============================================================================
// I2C master bit sequencer - shared types and constants
// Command codes, pin and sequencer state types, and the phase tables that
// map a command and phase index onto the SCL and SDA pin levels.
// ============================================================================
package i2cm_pkg;

    // Command / item kind codes carried on tuser
    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // No command in progress
    localparam op_t CMD_IDLE = OP_TICK;

    localparam int unsigned HOLD_WIDTH  = 16;
    localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = 16'd100;
    localparam int unsigned BYTE_BITS   = 8;
    localparam int unsigned PHASE_WIDTH = 5;

    // Phase counts per command
    localparam logic [PHASE_WIDTH-1:0] START_PHASES = 5'd6;
    localparam logic [PHASE_WIDTH-1:0] STOP_PHASES  = 5'd6;
    localparam logic [PHASE_WIDTH-1:0] WRITE_PHASES = 5'd28;
    localparam logic [PHASE_WIDTH-1:0] READ_PHASES  = 5'd21;

    // Landmark phases
    localparam logic [PHASE_WIDTH-1:0] WR_DATA_END  = 5'd24;
    localparam logic [PHASE_WIDTH-1:0] WR_ACK_REL   = 5'd25;
    localparam logic [PHASE_WIDTH-1:0] WR_ACK_HIGH  = 5'd26;
    localparam logic [PHASE_WIDTH-1:0] RD_BITS_BEG  = 5'd2;
    localparam logic [PHASE_WIDTH-1:0] RD_ACK_DRIVE = 5'd18;
    localparam logic [PHASE_WIDTH-1:0] RD_ACK_HIGH  = 5'd19;

    typedef struct packed {
        logic scl;
        logic sda_low;
    } pins_t;

    // Input item: tdata carries sda_level, send_ack, write_data (high bits first)
    typedef struct packed {
        op_t        op;
        logic       sda_level;
        logic       send_ack;
        logic [7:0] write_data;
    } item_t;

    // Result item, scl_out in the lowest bit
    typedef struct packed {
        logic       rejected;
        logic       ack_missing;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive_low;
        logic       scl_out;
    } res_t;

    localparam int unsigned RES_WIDTH = $bits(res_t);

    // Sequencer state other than the phase timer
    typedef struct packed {
        pins_t                  pins;
        op_t                    cmd;
        logic [PHASE_WIDTH-1:0] phase;
        logic [7:0]             shift;
        logic                   ack_req;
        logic                   ack_status;
        logic [7:0]             last_read;
    } seq_state_t;

    localparam seq_state_t STATE_RESET = '{
        pins:       '{scl: 1'b1, sda_low: 1'b0},
        cmd:        CMD_IDLE,
        phase:      '0,
        shift:      '0,
        ack_req:    1'b0,
        ack_status: 1'b0,
        last_read:  '0
    };

    function automatic logic [PHASE_WIDTH-1:0] phase_total(op_t cmd);
        logic [PHASE_WIDTH-1:0] total;
        case (cmd)
            OP_START: total = START_PHASES;
            OP_STOP:  total = STOP_PHASES;
            OP_WRITE: total = WRITE_PHASES;
            OP_READ:  total = READ_PHASES;
            default:  total = '0;
        endcase
        return total;
    endfunction

    // Pin change made on entry to phase idx of command cmd
    function automatic pins_t apply_pins(op_t cmd, logic [PHASE_WIDTH-1:0] idx,
                                         logic [7:0] shift, pins_t cur);
        pins_t                  p;
        logic [2:0]             bit_no;
        logic [PHASE_WIDTH-1:0] base;
        logic [1:0]             slot;
        p      = cur;
        bit_no = '0;
        // Bit number of a write data phase: count the three-phase groups passed
        for (int k = 1; k < BYTE_BITS; k++)
        begin
            if (idx >= PHASE_WIDTH'(3 * k))
                bit_no = 3'(k);
        end
        base = {1'b0, bit_no, 1'b0} + {2'b00, bit_no};
        slot = 2'(idx - base);
        case (cmd)
            OP_START:
            begin
                if (idx == 5'd0 || idx == 5'd2)
                    p.scl = 1'b1;
                else if (idx == 5'd4)
                    p.scl = 1'b0;
                else if (idx == 5'd3)
                    p.sda_low = 1'b1;
                else
                    p.sda_low = 1'b0;
            end
            OP_STOP:
            begin
                if (idx == 5'd0)
                    p.scl = 1'b0;
                else if (idx == 5'd2 || idx == 5'd4)
                    p.scl = 1'b1;
                else if (idx == 5'd5)
                    p.sda_low = 1'b0;
                else
                    p.sda_low = 1'b1;
            end
            OP_WRITE:
            begin
                if (idx < WR_DATA_END)
                begin
                    if (slot == 2'd0)
                        p.scl = 1'b0;
                    else if (slot == 2'd1)
                        p.sda_low = ~shift[~bit_no];
                    else
                        p.scl = 1'b1;
                end
                else if (idx == WR_DATA_END)
                    p.scl = 1'b0;
                else if (idx == WR_ACK_REL)
                    p.sda_low = 1'b0;
                else if (idx == WR_ACK_HIGH)
                    p.scl = 1'b1;
                else
                    p.scl = 1'b0;
            end
            OP_READ:
            begin
                if (idx == 5'd0)
                    p.scl = 1'b0;
                else if (idx == 5'd1)
                    p.sda_low = 1'b0;
                else if (idx < RD_ACK_DRIVE)
                    p.scl = ~idx[0];
                else if (idx == RD_ACK_DRIVE)
                    p.sda_low = 1'b1;
                else if (idx == RD_ACK_HIGH)
                    p.scl = 1'b1;
                else
                    p.scl = 1'b0;
            end
            default:
            begin
                p = cur;
            end
        endcase
        return p;
    endfunction

endpackage

### hw/rtl/i2cm_step.sv
// ============================================================================
// I2C master bit sequencer - item step logic
// Combinational next-state and result for one registered item: starts or
// rejects a command, counts a tick down, or ends a phase and moves on or idles.
// ============================================================================
module i2cm_step
#(
    parameter int unsigned COUNT_WIDTH = 16
)
(
    input  i2cm_pkg::seq_state_t                state,
    input  logic [COUNT_WIDTH-1:0]              count,
    input  i2cm_pkg::item_t                     item,
    input  logic [i2cm_pkg::HOLD_WIDTH-1:0]     hold,
    output i2cm_pkg::seq_state_t                state_next,
    output logic [COUNT_WIDTH-1:0]              count_next,
    output i2cm_pkg::res_t                      res
);
    import i2cm_pkg::*;

    logic                   busy;
    logic                   done;
    logic                   rej;
    logic [COUNT_WIDTH-1:0] load;
    logic [PHASE_WIDTH-1:0] phase_inc;
    seq_state_t             ended;
    logic                   seq_end;

    assign busy = (state.cmd != CMD_IDLE);
    assign load = COUNT_WIDTH'(hold);

    // Close the current phase: sample, step the index, finish or re-arm
    always_comb
    begin
        ended = state;
        if (state.cmd == OP_WRITE && state.phase == WR_ACK_HIGH)
            ended.ack_status = item.sda_level;
        if (state.cmd == OP_READ && state.phase >= RD_BITS_BEG
            && state.phase < RD_ACK_DRIVE && !state.phase[0])
            ended.shift = {state.shift[6:0], item.sda_level};
        phase_inc = state.phase + 5'd1;
        if (state.cmd == OP_READ && phase_inc == RD_ACK_DRIVE && !state.ack_req)
            phase_inc = RD_ACK_HIGH;
        seq_end = (phase_inc >= phase_total(state.cmd));
        if (seq_end)
        begin
            if (state.cmd == OP_READ)
                ended.last_read = ended.shift;
            ended.cmd   = CMD_IDLE;
            ended.phase = '0;
        end
        else
        begin
            ended.phase = phase_inc;
            ended.pins  = apply_pins(state.cmd, phase_inc, ended.shift, state.pins);
        end
    end

    // Dispatch on the item kind
    always_comb
    begin
        state_next = state;
        count_next = count;
        done       = 1'b0;
        rej        = 1'b0;
        case (item.op)
            OP_TICK:
            begin
                if (busy)
                begin
                    if (count > COUNT_WIDTH'(1))
                        count_next = count - COUNT_WIDTH'(1);
                    else
                    begin
                        state_next = ended;
                        count_next = seq_end ? '0 : load;
                        done       = seq_end;
                    end
                end
            end
            OP_START, OP_STOP, OP_WRITE, OP_READ:
            begin
                if (busy)
                    rej = 1'b1;
                else
                begin
                    state_next.cmd   = item.op;
                    state_next.phase = '0;
                    if (item.op == OP_WRITE)
                        state_next.shift = item.write_data;
                    if (item.op == OP_READ)
                    begin
                        state_next.shift   = '0;
                        state_next.ack_req = item.send_ack;
                    end
                    state_next.pins = apply_pins(item.op, '0, state_next.shift,
                                                 state.pins);
                    count_next = load;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    // Assemble the result from the updated state
    always_comb
    begin
        res.scl_out       = state_next.pins.scl;
        res.sda_drive_low = state_next.pins.sda_low;
        res.busy_res      = (state_next.cmd != CMD_IDLE);
        res.done_res      = done;
        res.read_data     = state_next.last_read;
        res.ack_missing   = state_next.ack_status;
        res.rejected      = rej;
    end

endmodule

### hw/rtl/i2c_master_bit_sequencer.sv
// ============================================================================
// I2C master bit sequencer - top level
// Input item register, step logic and result register around the I2C pin
// phase sequencer, with the hold_ticks configuration register.
// ============================================================================
// Usage:
//   s_* carries items: tuser holds the kind (tick, start, stop, write, read),
//   tdata the write byte, the ACK request and the sampled SDA level. Feed one
//   tick item per bus tick; a command is taken only while no sequence runs,
//   otherwise its result comes back with rejected set.
//   m_* returns exactly one result per item: pin levels, busy, done, the last
//   read byte, the last write's ACK status and the rejected flag.
//   cfg_* writes hold_ticks; the port is always ready. Write it only while
//   the block is idle.
// Timing:
//   An item lands in the input register on transfer; the step logic between
//   the two registers is combinational, and its result is written to the
//   result register once that register is free or m_tready is high. One item
//   per clock is sustained while m_tready stays high.
// Reset and stall:
//   Reset releases SDA, leaves SCL high, goes idle and loads hold_ticks
//   with 100. While m_tready is low the result holds, the input register
//   holds its item and s_tready falls once both are full.
// ============================================================================
module i2c_master_bit_sequencer
#(
    parameter int unsigned COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] write_data, [8] send_ack, [9] sda_level
    input  logic [2:0]  s_tuser,   // [2:0] op
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] scl_out, [1] sda_drive_low, [2] busy_res,
                                   // [3] done_res, [11:4] read_data,
                                   // [12] ack_missing, [13] rejected
    // Configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data   // hold_ticks
);
    import i2cm_pkg::*;

    logic [HOLD_WIDTH-1:0]  hold_reg;
    item_t                  item_reg;
    logic                   item_valid_reg;
    seq_state_t             state_reg;
    seq_state_t             state_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    res_t                   res_reg;
    res_t                   res_next;
    logic                   res_valid_reg;
    logic                   advance;
    logic                   in_xfer;

    assign advance   = item_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready  = !item_valid_reg || advance;
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = res_valid_reg;
    assign m_tdata   = {(16 - RES_WIDTH)'(0), res_reg};

    i2cm_step
    #(
        .COUNT_WIDTH (COUNT_WIDTH)
    )
    u_step
    (
        .state      (state_reg),
        .count      (count_reg),
        .item       (item_reg),
        .hold       (hold_reg),
        .state_next (state_next),
        .count_next (count_next),
        .res        (res_next)
    );

    // Hold the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= HOLD_RESET;
        else if (cfg_valid && cfg_ready)
            hold_reg <= cfg_data;
    end

    // Capture an item on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_xfer)
            item_valid_reg <= 1'b1;
        else if (advance)
            item_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.op         <= op_t'(s_tuser);
            item_reg.write_data <= s_tdata[7:0];
            item_reg.send_ack   <= s_tdata[8];
            item_reg.sda_level  <= s_tdata[9];
        end
    end

    // Advance the sequencer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= 1'b1;
        end
        else if (m_tready)
            res_valid_reg <= 1'b0;
    end

    // Drop the result into the output register
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    // An idle sequencer sits at phase zero with its timer cleared
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.cmd == CMD_IDLE |-> state_reg.phase == '0 && count_reg == '0)
        else $error("idle sequencer with live phase or timer");

    // The phase index stays inside the longest sequence
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase < WRITE_PHASES)
        else $error("phase index out of range");

    // A rejected command leaves a sequence running
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.rejected |-> res_reg.busy_res)
        else $error("command rejected while idle");

    // Completion leaves the block idle and never coincides with a rejection
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.done_res |-> !res_reg.busy_res && !res_reg.rejected)
        else $error("done reported while busy");

    // A result is produced exactly when a registered item is stepped
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("stepped item produced no result");

endmodule
